>>> src/sbe_pkg.sv
// ----------------------------------------------------------------------------
// Stack bytecode executor package
// Shared opcodes, status codes, stack sizing and IEEE double constants.
// ----------------------------------------------------------------------------
package sbe_pkg;

   localparam int unsigned STACK_DEPTH = 256;
   localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
   localparam int unsigned CNT_W       = ADDR_W + 1;

   localparam logic [31:0] PUSH_LENGTH = 32'd9;
   localparam logic [31:0] OP_LENGTH   = 32'd1;

   localparam logic [7:0] OP_NOP   = 8'd0;
   localparam logic [7:0] OP_PUSH  = 8'd1;
   localparam logic [7:0] OP_ADD   = 8'd2;
   localparam logic [7:0] OP_JMP   = 8'd3;
   localparam logic [7:0] OP_PRINT = 8'd4;
   localparam logic [7:0] OP_DUP   = 8'd5;
   localparam logic [7:0] OP_HALT  = 8'd6;

   localparam logic [2:0] ST_RUN       = 3'd0;
   localparam logic [2:0] ST_DONE      = 3'd1;
   localparam logic [2:0] ST_ILLEGAL   = 3'd2;
   localparam logic [2:0] ST_OVERFLOW  = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;

   localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
   localparam logic [10:0] EXP_MAX     = 11'h7FF;

endpackage

>>> src/stack_bytecode_executor.sv
// ----------------------------------------------------------------------------
// Stack bytecode executor
// Runs one decoded instruction per request against a stack of IEEE doubles.
// ----------------------------------------------------------------------------
// NOP, JMP, PUSH, HALT, errors, stopped and past-the-end requests go from the
// execute state straight to the response; PRINT and DUP read the stack first,
// and ADD reads it twice and then waits on the adder. One request is in work at
// a time; the next can be taken in the cycle after the response is queued.
// Reset clears pc, stack count, stop flag and program_length; stack contents
// are left undefined and need no clearing pass.
module stack_bytecode_executor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_opcode,
   input  logic [63:0] req_push_value,
   input  logic [31:0] req_jump_target,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_print_valid,
   output logic [63:0] rsp_print_value,
   output logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int unsigned AW = sbe_pkg::ADDR_W;
   localparam int unsigned CW = sbe_pkg::CNT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(sbe_pkg::STACK_DEPTH - 1);

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_RD1, S_RD2, S_ADD, S_RESP} state_type;

   state_type      state_ff, state_in;
   logic [31:0]    pc_ff, pc_in;
   logic [31:0]    len_ff, len_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           stopped_ff, stopped_in;
   logic [2:0]     stop_status_ff, stop_status_in;
   logic [7:0]     op_ff, op_in;
   logic [63:0]    imm_ff, imm_in;
   logic [31:0]    tgt_ff, tgt_in;
   logic [63:0]    a_ff, a_in;
   logic [31:0]    res_npc_ff, res_npc_in;
   logic           res_pvalid_ff, res_pvalid_in;
   logic [63:0]    res_pval_ff, res_pval_in;
   logic [2:0]     res_status_ff, res_status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_npc_ff, rsp_npc_in;
   logic           rsp_pvalid_ff, rsp_pvalid_in;
   logic [63:0]    rsp_pval_ff, rsp_pval_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;

   logic [63:0]    mem [sbe_pkg::STACK_DEPTH];
   logic [63:0]    rd_data_ff;
   logic           rd_en, wr_en;
   logic [AW-1:0]  rd_addr, wr_addr;
   logic [63:0]    wr_data;

   logic           fadd_start, fadd_done;
   logic [63:0]    fadd_sum;

   logic           fin, fail;
   logic [31:0]    fin_npc;
   logic [2:0]     fail_status;
   logic           full, empty;
   logic [CW-1:0]  cnt_m1, cnt_m2;

   sbe_fadd u_fadd (
      .clock (clock),
      .reset (reset),
      .start (fadd_start),
      .op_a  (a_ff),
      .op_b  (rd_data_ff),
      .done  (fadd_done),
      .sum   (fadd_sum)
   );

   always_comb begin
      full   = count_ff >= FULL_COUNT;
      empty  = count_ff == '0;
      cnt_m1 = count_ff - CW'(1);
      cnt_m2 = count_ff - CW'(2);

      state_in       = state_ff;
      pc_in          = pc_ff;
      len_in         = csr_wr_en ? csr_wr_data : len_ff;
      count_in       = count_ff;
      stopped_in     = stopped_ff;
      stop_status_in = stop_status_ff;
      op_in          = op_ff;
      imm_in         = imm_ff;
      tgt_in         = tgt_ff;
      a_in           = a_ff;
      res_npc_in     = res_npc_ff;
      res_pvalid_in  = res_pvalid_ff;
      res_pval_in    = res_pval_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_npc_in     = rsp_npc_ff;
      rsp_pvalid_in  = rsp_pvalid_ff;
      rsp_pval_in    = rsp_pval_ff;
      rsp_status_in  = rsp_status_ff;

      rd_en       = 1'b0;
      rd_addr     = cnt_m1[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = count_ff[AW-1:0];
      wr_data     = imm_ff;
      fadd_start  = 1'b0;
      fin         = 1'b0;
      fin_npc     = pc_ff + sbe_pkg::OP_LENGTH;
      fail        = 1'b0;
      fail_status = sbe_pkg::ST_DONE;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               imm_in   = req_push_value;
               tgt_in   = req_jump_target;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_pvalid_in = 1'b0;
            res_pval_in   = '0;
            if (stopped_ff) begin
               res_npc_in    = pc_ff;
               res_status_in = stop_status_ff;
               state_in      = S_RESP;
            end else if (pc_ff >= len_ff) begin
               res_npc_in    = pc_ff;
               res_status_in = sbe_pkg::ST_DONE;
               state_in      = S_RESP;
            end else begin
               case (op_ff)
                  sbe_pkg::OP_NOP: begin
                     fin = 1'b1;
                  end
                  sbe_pkg::OP_PUSH: begin
                     if (full) begin
                        fail        = 1'b1;
                        fail_status = sbe_pkg::ST_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                        fin      = 1'b1;
                        fin_npc  = pc_ff + sbe_pkg::PUSH_LENGTH;
                     end
                  end
                  sbe_pkg::OP_ADD: begin
                     if (count_ff < CW'(2)) begin
                        fail        = 1'b1;
                        fail_status = sbe_pkg::ST_UNDERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_RD1;
                     end
                  end
                  sbe_pkg::OP_JMP: begin
                     fin     = 1'b1;
                     fin_npc = tgt_ff;
                  end
                  sbe_pkg::OP_PRINT: begin
                     if (empty) begin
                        fail        = 1'b1;
                        fail_status = sbe_pkg::ST_UNDERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_RD1;
                     end
                  end
                  sbe_pkg::OP_DUP: begin
                     if (empty) begin
                        fail        = 1'b1;
                        fail_status = sbe_pkg::ST_UNDERFLOW;
                     end else if (full) begin
                        fail        = 1'b1;
                        fail_status = sbe_pkg::ST_OVERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_RD1;
                     end
                  end
                  sbe_pkg::OP_HALT: begin
                     fail        = 1'b1;
                     fail_status = sbe_pkg::ST_DONE;
                  end
                  default: begin
                     fail        = 1'b1;
                     fail_status = sbe_pkg::ST_ILLEGAL;
                  end
               endcase
            end
         end
         S_RD1: begin
            case (op_ff)
               sbe_pkg::OP_PRINT: begin
                  res_pvalid_in = 1'b1;
                  res_pval_in   = rd_data_ff;
                  count_in      = cnt_m1;
                  fin           = 1'b1;
               end
               sbe_pkg::OP_DUP: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data_ff;
                  count_in = count_ff + CW'(1);
                  fin      = 1'b1;
               end
               default: begin
                  a_in     = rd_data_ff;
                  rd_en    = 1'b1;
                  rd_addr  = cnt_m2[AW-1:0];
                  state_in = S_RD2;
               end
            endcase
         end
         S_RD2: begin
            fadd_start = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            if (fadd_done) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[AW-1:0];
               wr_data  = fadd_sum;
               count_in = cnt_m1;
               fin      = 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_npc_in    = res_npc_ff;
               rsp_pvalid_in = res_pvalid_ff;
               rsp_pval_in   = res_pval_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         pc_in      = fin_npc;
         res_npc_in = fin_npc;
         state_in   = S_RESP;
         if (fin_npc >= len_ff) begin
            res_status_in  = sbe_pkg::ST_DONE;
            stopped_in     = 1'b1;
            stop_status_in = sbe_pkg::ST_DONE;
         end else begin
            res_status_in = sbe_pkg::ST_RUN;
         end
      end
      if (fail) begin
         res_npc_in     = pc_ff;
         res_status_in  = fail_status;
         stopped_in     = 1'b1;
         stop_status_in = fail_status;
         state_in       = S_RESP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pc_ff          <= '0;
         len_ff         <= '0;
         count_ff       <= '0;
         stopped_ff     <= 1'b0;
         stop_status_ff <= sbe_pkg::ST_RUN;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pc_ff          <= pc_in;
         len_ff         <= len_in;
         count_ff       <= count_in;
         stopped_ff     <= stopped_in;
         stop_status_ff <= stop_status_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff         <= op_in;
      imm_ff        <= imm_in;
      tgt_ff        <= tgt_in;
      a_ff          <= a_in;
      res_npc_ff    <= res_npc_in;
      res_pvalid_ff <= res_pvalid_in;
      res_pval_ff   <= res_pval_in;
      res_status_ff <= res_status_in;
      rsp_npc_ff    <= rsp_npc_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
      rsp_pval_ff   <= rsp_pval_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_pc     = rsp_npc_ff;
   assign rsp_print_valid = rsp_pvalid_ff;
   assign rsp_print_value = rsp_pval_ff;
   assign rsp_status      = rsp_status_ff;

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("stop flag cleared without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CW'(sbe_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_print_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |->
         rsp_status == sbe_pkg::ST_RUN || rsp_status == sbe_pkg::ST_DONE)
      else $error("print value reported with an error status");

   a_fadd_only_add: assert property (@(posedge clock) disable iff (reset)
      fadd_start |-> op_ff == sbe_pkg::OP_ADD)
      else $error("adder started for an instruction other than add");

endmodule

>>> src/sbe_fadd.sv
// ----------------------------------------------------------------------------
// Iterative double-precision adder
// Adds two IEEE doubles with round-to-nearest-even in these steps:
// unpack, align and add, a stepwise normalizing shift, then rounding.
// ----------------------------------------------------------------------------
module sbe_fadd (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] sum
);

   localparam logic [10:0] EXP_MAX_L = sbe_pkg::EXP_MAX;

   typedef enum logic [1:0] {F_IDLE, F_ALIGN, F_NORM, F_ROUND} fstate_type;

   fstate_type   state_ff, state_in;
   logic         done_ff, done_in;
   logic [63:0]  sum_ff, sum_in;
   logic         sign_ff, sign_in;
   logic         zsign_ff, zsign_in;
   logic         sub_ff, sub_in;
   logic [11:0]  exp_ff, exp_in;
   logic [55:0]  mbig_ff, mbig_in;
   logic [55:0]  msmall_ff, msmall_in;
   logic [10:0]  diff_ff, diff_in;
   logic [56:0]  man_ff, man_in;

   logic [10:0]  ea, eb, eba, ebb;
   logic         nan_a, nan_b, inf_a, inf_b, a_big;
   logic [5:0]   shamt;
   logic [111:0] wide;
   logic [55:0]  aligned;
   logic [56:0]  raw;
   logic         round_up;
   logic [53:0]  rounded;
   logic [11:0]  exp_out;
   logic [51:0]  frac_out;

   always_comb begin
      ea    = op_a[62:52];
      eb    = op_b[62:52];
      eba   = (ea == 11'd0) ? 11'd1 : ea;
      ebb   = (eb == 11'd0) ? 11'd1 : eb;
      nan_a = (ea == EXP_MAX_L) && (op_a[51:0] != 52'd0);
      nan_b = (eb == EXP_MAX_L) && (op_b[51:0] != 52'd0);
      inf_a = (ea == EXP_MAX_L) && (op_a[51:0] == 52'd0);
      inf_b = (eb == EXP_MAX_L) && (op_b[51:0] == 52'd0);
      a_big = op_a[62:0] >= op_b[62:0];

      shamt   = (diff_ff > 11'd63) ? 6'd63 : diff_ff[5:0];
      wide    = {msmall_ff, 56'd0} >> shamt;
      aligned = {wide[111:57], wide[56] | (|wide[55:0])};
      raw     = sub_ff ? ({1'b0, mbig_ff} - {1'b0, aligned})
                       : ({1'b0, mbig_ff} + {1'b0, aligned});

      round_up = man_ff[2] & (man_ff[1] | man_ff[0] | man_ff[3]);
      rounded  = {1'b0, man_ff[55:3]} + {53'd0, round_up};
      if (rounded[53]) begin
         exp_out  = exp_ff + 12'd1;
         frac_out = rounded[52:1];
      end else begin
         exp_out  = rounded[52] ? exp_ff : 12'd0;
         frac_out = rounded[51:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      sum_in    = sum_ff;
      sign_in   = sign_ff;
      zsign_in  = zsign_ff;
      sub_in    = sub_ff;
      exp_in    = exp_ff;
      mbig_in   = mbig_ff;
      msmall_in = msmall_ff;
      diff_in   = diff_ff;
      man_in    = man_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               if (nan_a) begin
                  sum_in  = op_a | sbe_pkg::QUIET_BIT;
                  done_in = 1'b1;
               end else if (nan_b) begin
                  sum_in  = op_b | sbe_pkg::QUIET_BIT;
                  done_in = 1'b1;
               end else if (inf_a && inf_b && (op_a[63] != op_b[63])) begin
                  sum_in  = sbe_pkg::DEFAULT_NAN;
                  done_in = 1'b1;
               end else if (inf_a) begin
                  sum_in  = op_a;
                  done_in = 1'b1;
               end else if (inf_b) begin
                  sum_in  = op_b;
                  done_in = 1'b1;
               end else begin
                  zsign_in = op_a[63] & op_b[63];
                  sub_in   = op_a[63] ^ op_b[63];
                  if (a_big) begin
                     sign_in   = op_a[63];
                     exp_in    = {1'b0, eba};
                     mbig_in   = {ea != 11'd0, op_a[51:0], 3'd0};
                     msmall_in = {eb != 11'd0, op_b[51:0], 3'd0};
                     diff_in   = eba - ebb;
                  end else begin
                     sign_in   = op_b[63];
                     exp_in    = {1'b0, ebb};
                     mbig_in   = {eb != 11'd0, op_b[51:0], 3'd0};
                     msmall_in = {ea != 11'd0, op_a[51:0], 3'd0};
                     diff_in   = ebb - eba;
                  end
                  state_in = F_ALIGN;
               end
            end
         end
         F_ALIGN: begin
            if (raw == 57'd0) begin
               sum_in   = {zsign_ff, 63'd0};
               done_in  = 1'b1;
               state_in = F_IDLE;
            end else if (raw[56]) begin
               man_in   = {1'b0, raw[56:2], raw[1] | raw[0]};
               exp_in   = exp_ff + 12'd1;
               state_in = F_NORM;
            end else begin
               man_in   = raw;
               state_in = F_NORM;
            end
         end
         F_NORM: begin
            if (!man_ff[55] && (exp_ff > 12'd1)) begin
               if ((man_ff[55:40] == 16'd0) && (exp_ff > 12'd16)) begin
                  man_in = {man_ff[40:0], 16'd0};
                  exp_in = exp_ff - 12'd16;
               end else if ((man_ff[55:52] == 4'd0) && (exp_ff > 12'd4)) begin
                  man_in = {man_ff[52:0], 4'd0};
                  exp_in = exp_ff - 12'd4;
               end else begin
                  man_in = {man_ff[55:0], 1'b0};
                  exp_in = exp_ff - 12'd1;
               end
            end else begin
               state_in = F_ROUND;
            end
         end
         F_ROUND: begin
            if (exp_out >= 12'd2047) begin
               sum_in = {sign_ff, EXP_MAX_L, 52'd0};
            end else begin
               sum_in = {sign_ff, exp_out[10:0], frac_out};
            end
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sum_ff    <= sum_in;
      sign_ff   <= sign_in;
      zsign_ff  <= zsign_in;
      sub_ff    <= sub_in;
      exp_ff    <= exp_in;
      mbig_ff   <= mbig_in;
      msmall_ff <= msmall_in;
      diff_ff   <= diff_in;
      man_ff    <= man_in;
   end

   assign done = done_ff;
   assign sum  = sum_ff;

endmodule

>>> bench/sbe_checker.sv
// ----------------------------------------------------------------------------
// Stack bytecode executor checker
// Watches the request, response and register ports, keeps its own copy of
// the stack, pc and stop state, predicts every response and compares it.
// ----------------------------------------------------------------------------
module sbe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_opcode,
   input  logic [63:0] req_push_value,
   input  logic [31:0] req_jump_target,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_next_pc,
   input  logic        rsp_print_valid,
   input  logic [63:0] rsp_print_value,
   input  logic [2:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          mismatch_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] next_pc;
      logic        print_valid;
      logic [63:0] print_value;
      logic [2:0]  status;
   } step_result_type;

   step_result_type expected_results[$];
   logic [63:0] value_stack [sbe_pkg::STACK_DEPTH];
   int          stack_top;
   logic [31:0] pc;
   logic        stopped;
   logic [2:0]  stop_status;
   logic [31:0] program_length;

   initial mismatch_count = 0;
   assign pending_count = expected_results.size();

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic logic is_nan(input logic [63:0] v);
      return v[62:52] == sbe_pkg::EXP_MAX && v[51:0] != 52'd0;
   endfunction

   function automatic logic [63:0] double_sum(input logic [63:0] a, input logic [63:0] b);
      logic a_inf;
      logic b_inf;
      a_inf = a[62:52] == sbe_pkg::EXP_MAX && a[51:0] == 52'd0;
      b_inf = b[62:52] == sbe_pkg::EXP_MAX && b[51:0] == 52'd0;
      if (is_nan(a)) return a | sbe_pkg::QUIET_BIT;
      if (is_nan(b)) return b | sbe_pkg::QUIET_BIT;
      if (a_inf && b_inf && a[63] != b[63]) return sbe_pkg::DEFAULT_NAN;
      return $realtobits($bitstoreal(a) + $bitstoreal(b));
   endfunction

   function automatic logic stack_full();
      return stack_top >= int'(sbe_pkg::STACK_DEPTH) - 2;
   endfunction

   task automatic execute(input logic [7:0] op, input logic [63:0] imm, input logic [31:0] tgt);
      step_result_type r;
      r.next_pc = pc;
      r.print_valid = 1'b0;
      r.print_value = 64'd0;
      r.status = sbe_pkg::ST_RUN;
      if (stopped) begin
         r.status = stop_status;
      end else if (pc >= program_length) begin
         r.status = sbe_pkg::ST_DONE;
      end else begin
         case (op)
            sbe_pkg::OP_NOP: r.next_pc = pc + sbe_pkg::OP_LENGTH;
            sbe_pkg::OP_PUSH: begin
               if (stack_full()) begin
                  r.status = sbe_pkg::ST_OVERFLOW;
               end else begin
                  stack_top++;
                  value_stack[stack_top] = imm;
                  r.next_pc = pc + sbe_pkg::PUSH_LENGTH;
               end
            end
            sbe_pkg::OP_ADD: begin
               if (stack_top < 1) begin
                  r.status = sbe_pkg::ST_UNDERFLOW;
               end else begin
                  value_stack[stack_top - 1] =
                     double_sum(value_stack[stack_top], value_stack[stack_top - 1]);
                  stack_top--;
                  r.next_pc = pc + sbe_pkg::OP_LENGTH;
               end
            end
            sbe_pkg::OP_JMP: r.next_pc = tgt;
            sbe_pkg::OP_PRINT: begin
               if (stack_top < 0) begin
                  r.status = sbe_pkg::ST_UNDERFLOW;
               end else begin
                  r.print_value = value_stack[stack_top];
                  r.print_valid = 1'b1;
                  stack_top--;
                  r.next_pc = pc + sbe_pkg::OP_LENGTH;
               end
            end
            sbe_pkg::OP_DUP: begin
               if (stack_top < 0) begin
                  r.status = sbe_pkg::ST_UNDERFLOW;
               end else if (stack_full()) begin
                  r.status = sbe_pkg::ST_OVERFLOW;
               end else begin
                  value_stack[stack_top + 1] = value_stack[stack_top];
                  stack_top++;
                  r.next_pc = pc + sbe_pkg::OP_LENGTH;
               end
            end
            sbe_pkg::OP_HALT: r.status = sbe_pkg::ST_DONE;
            default: r.status = sbe_pkg::ST_ILLEGAL;
         endcase
         if (r.status == sbe_pkg::ST_RUN && r.next_pc >= program_length)
            r.status = sbe_pkg::ST_DONE;
         pc = r.next_pc;
         if (r.status != sbe_pkg::ST_RUN) begin
            stopped = 1'b1;
            stop_status = r.status;
         end
      end
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin
      step_result_type e;
      if (reset) begin
         expected_results.delete();
         stack_top = -1;
         pc = 32'd0;
         stopped = 1'b0;
         stop_status = sbe_pkg::ST_RUN;
         program_length = 32'd0;
      end else begin
         if (csr_wr_en) program_length = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response");
            end else begin
               e = expected_results.pop_front();
               if (rsp_next_pc !== e.next_pc)
                  report_mismatch($sformatf("next_pc %h, expected %h", rsp_next_pc, e.next_pc));
               if (rsp_print_valid !== e.print_valid)
                  report_mismatch($sformatf("print_valid %b, expected %b",
                                            rsp_print_valid, e.print_valid));
               if (rsp_print_value !== e.print_value)
                  report_mismatch($sformatf("print_value %h, expected %h",
                                            rsp_print_value, e.print_value));
               if (rsp_status !== e.status)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, e.status));
            end
         end
         if (req_valid && req_ready) execute(req_opcode, req_push_value, req_jump_target);
      end
   end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Stack bytecode executor testbench
// Runs one long program: directed special values, then random well-formed
// instruction streams under several idle and stall mixes, then one randomly
// chosen way of stopping followed by requests that must be ignored.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_opcode = sbe_pkg::OP_NOP;
   logic [63:0] req_push_value = 64'd0;
   logic [31:0] req_jump_target = 32'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_pc;
   logic        rsp_print_valid;
   logic [63:0] rsp_print_value;
   logic [2:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;
   int          mismatch_count;
   int          pending_count;

   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;
   logic [31:0] exec_pc = 32'd0;
   int          stack_depth = 0;
   logic [31:0] prog_len = 32'd0;

   always #5 clock = ~clock;

   stack_bytecode_executor dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_push_value(req_push_value), .req_jump_target(req_jump_target),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_next_pc(rsp_next_pc),
      .rsp_print_valid(rsp_print_valid), .rsp_print_value(rsp_print_value),
      .rsp_status(rsp_status), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   sbe_checker u_checker (.*);

   always @(posedge clock) begin
      if (!reset) rsp_ready <= $urandom_range(99) >= stall_pct;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic issue(input logic [7:0] op, input logic [63:0] imm, input logic [31:0] tgt);
      case (op)
         sbe_pkg::OP_PUSH: begin
            exec_pc = exec_pc + sbe_pkg::PUSH_LENGTH;
            stack_depth++;
         end
         sbe_pkg::OP_ADD, sbe_pkg::OP_PRINT: begin
            exec_pc = exec_pc + sbe_pkg::OP_LENGTH;
            stack_depth--;
         end
         sbe_pkg::OP_DUP: begin
            exec_pc = exec_pc + sbe_pkg::OP_LENGTH;
            stack_depth++;
         end
         sbe_pkg::OP_JMP: exec_pc = tgt;
         default: exec_pc = exec_pc + sbe_pkg::OP_LENGTH;
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_push_value <= imm;
      req_jump_target <= tgt;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      prog_len = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_double();
      case ($urandom_range(11))
         0: return 64'h0000_0000_0000_0000;
         1: return 64'h8000_0000_0000_0000;
         2: return 64'h7FF0_0000_0000_0000;
         3: return 64'hFFF0_0000_0000_0000;
         4: return 64'h7FF4_0000_0000_0001;
         5: return {1'b0, 11'd0, 20'd0, $urandom()};
         6: return {1'($urandom_range(1)), 11'h433, 20'd0, 32'($urandom_range(1000))};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic jump_low();
      issue(sbe_pkg::OP_JMP, {$urandom(), $urandom()}, $urandom_range(prog_len - 64, 0));
   endtask

   task automatic random_step();
      int r;
      logic [7:0] op;
      r = $urandom_range(99);
      op = r < 15 ? sbe_pkg::OP_NOP : r < 45 ? sbe_pkg::OP_PUSH : r < 60 ? sbe_pkg::OP_ADD :
           r < 68 ? sbe_pkg::OP_JMP : r < 85 ? sbe_pkg::OP_PRINT : sbe_pkg::OP_DUP;
      if ((op == sbe_pkg::OP_ADD && stack_depth < 2) ||
          ((op == sbe_pkg::OP_PRINT || op == sbe_pkg::OP_DUP) && stack_depth < 1))
         op = sbe_pkg::OP_PUSH;
      if ((op == sbe_pkg::OP_PUSH || op == sbe_pkg::OP_DUP) &&
          stack_depth >= int'(sbe_pkg::STACK_DEPTH) - 2)
         op = sbe_pkg::OP_PRINT;
      if (exec_pc > prog_len - 64 || op == sbe_pkg::OP_JMP) begin
         jump_low();
      end else begin
         issue(op, op == sbe_pkg::OP_PUSH ? random_double() : {$urandom(), $urandom()},
               $urandom());
      end
   endtask

   initial begin
      logic [31:0] new_len;
      logic [7:0]  op;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_length(32'hFFFF_FFFF);

      issue(sbe_pkg::OP_NOP, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'h0000_0000_0000_0000, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'h7FEF_FFFF_FFFF_FFFF, 32'd0);
      issue(sbe_pkg::OP_ADD, 64'd0, 32'd0);
      issue(sbe_pkg::OP_DUP, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PRINT, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'hFFF0_0000_0000_0000, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'h7FF0_0000_0000_0000, 32'd0);
      issue(sbe_pkg::OP_ADD, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'h7FF4_0000_0000_0000, 32'd0);
      issue(sbe_pkg::OP_ADD, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PRINT, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'h8000_0000_0000_0000, 32'd0);
      issue(sbe_pkg::OP_PUSH, 64'h0000_0000_0000_0001, 32'd0);
      issue(sbe_pkg::OP_ADD, 64'd0, 32'd0);
      issue(sbe_pkg::OP_PRINT, 64'd0, 32'd0);
      issue(sbe_pkg::OP_JMP, 64'd0, 32'hFFFF_FFF9);
      issue(sbe_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
      issue(sbe_pkg::OP_PRINT, 64'd0, 32'd0);
      issue(sbe_pkg::OP_JMP, 64'd0, 32'd0);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = phase == 1 || phase == 3 ? (phase == 1 ? 77 : 32) : 0;
         stall_pct = phase == 2 || phase == 3 ? (phase == 2 ? 77 : 32) : 0;
         for (int i = 0; i < 370; i++) begin
            random_step();
            if ($urandom_range(99) == 0) begin
               idle_pct = 0;
               stall_pct = 0;
               repeat ($urandom_range(40, 1)) random_step();
               idle_pct = phase == 1 || phase == 3 ? (phase == 1 ? 77 : 32) : 0;
               stall_pct = phase == 2 || phase == 3 ? (phase == 2 ? 77 : 32) : 0;
            end
         end
         drain();
         new_len = phase == 3 ? 32'hFFFF_FFFF : $urandom_range(32'hFFFF_FFFF, 32'h0010_0000);
         if (new_len <= exec_pc + 64 || exec_pc > 32'hFFFF_0000) new_len = 32'hFFFF_FFFF;
         write_length(new_len);
      end

      idle_pct = 20;
      stall_pct = 20;
      case ($urandom_range(5))
         0: issue(sbe_pkg::OP_HALT, {$urandom(), $urandom()}, $urandom());
         1: issue(8'($urandom_range(255, 7)), {$urandom(), $urandom()}, $urandom());
         2: begin
            while (stack_depth < int'(sbe_pkg::STACK_DEPTH) - 2) begin
               if (exec_pc > prog_len - 64) jump_low();
               else issue(sbe_pkg::OP_PUSH, random_double(), 32'd0);
            end
            issue($urandom_range(1) ? sbe_pkg::OP_PUSH : sbe_pkg::OP_DUP, random_double(),
                  32'd0);
         end
         3: begin
            while (stack_depth > 0) begin
               if (exec_pc > prog_len - 64) jump_low();
               else issue(sbe_pkg::OP_PRINT, 64'd0, 32'd0);
            end
            case ($urandom_range(2))
               0: op = sbe_pkg::OP_ADD;
               1: op = sbe_pkg::OP_PRINT;
               default: op = sbe_pkg::OP_DUP;
            endcase
            issue(op, 64'd0, 32'd0);
         end
         4: begin
            drain();
            write_length($urandom_range(1) ? 32'd0 : exec_pc);
            issue(8'($urandom_range(6)), random_double(), $urandom());
         end
         default: begin
            drain();
            write_length(exec_pc + 1);
            issue(sbe_pkg::OP_NOP, 64'd0, 32'd0);
         end
      endcase
      repeat (25) issue(8'($urandom()), {$urandom(), $urandom()}, $urandom());

      drain();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
